@@ rtl/core/glyph_blit_clip_pixel_pack_defines.svh @@
// Assertion macros for the glyph blitter.
`ifndef GLYPH_BLIT_CLIP_PIXEL_PACK_DEFINES_SVH
`define GLYPH_BLIT_CLIP_PIXEL_PACK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GBCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbcp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GBCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbcp assertion failed");

`endif

@@ rtl/core/gbcp_pkg.sv @@
// Types, constants and helper functions of the glyph blitter.
package gbcp_pkg;

  localparam int MAX_GLYPH_SIDE  = 256;
  localparam int MAX_SCREEN_SIDE = 4096;

  // Fixed field widths
  localparam int ORG_W   = 13;
  localparam int GSIDE_W = 9;
  localparam int SSIDE_W = 13;
  localparam int LB_W    = 15;
  localparam int FMT_W   = 2;
  localparam int PIX_W   = 24;
  localparam int OFF_W   = 26;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 15;

  // Glyph counters and position math
  localparam int CNT_W = $clog2(MAX_GLYPH_SIDE);
  localparam int CMP_W = (CNT_W + 1 > GSIDE_W) ? CNT_W + 1 : GSIDE_W;
  localparam int POS_W = ORG_W + 1;
  localparam int PROD_W = (POS_W - 1) + LB_W;

  typedef enum logic [CIDX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_GLYPH_WIDTH   = 3'd2,
    REG_GLYPH_ROWS    = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_LINE_BYTES    = 3'd6,
    REG_PIXEL_FORMAT  = 3'd7
  } cfg_idx_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_8BPP   = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_32BPP  = 2'd2,
    FMT_BAD    = 2'd3
  } pix_fmt_t;

  typedef enum logic [SIZE_W-1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } acc_size_t;

  // Zero acts as one, oversize clamps to the maximum side.
  function automatic logic [GSIDE_W-1:0] glyph_side(input logic [GSIDE_W-1:0] v);
    logic [GSIDE_W-1:0] res;
    res = v;
    if (v == '0) res = GSIDE_W'(1);
    else if (int'(v) > MAX_GLYPH_SIDE) res = GSIDE_W'(MAX_GLYPH_SIDE);
    return res;
  endfunction

  function automatic logic [SSIDE_W-1:0] screen_side(input logic [SSIDE_W-1:0] v);
    logic [SSIDE_W-1:0] res;
    res = v;
    if (int'(v) > MAX_SCREEN_SIDE) res = SSIDE_W'(MAX_SCREEN_SIDE);
    return res;
  endfunction

  function automatic logic [15:0] pack_rgb565(input logic [PIX_W-1:0] pix);
    return {pix[23:19], pix[15:10], pix[7:3]};
  endfunction

endpackage

@@ rtl/core/gbcp_pix_if.sv @@
// Pixel input channel.
interface gbcp_pix_if;
  import gbcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

@@ rtl/core/gbcp_wr_if.sv @@
// Frame-buffer write result channel.
interface gbcp_wr_if;
  import gbcp_pkg::*;

  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [OFF_W-1:0]  byte_offset;
  logic [DATA_W-1:0] write_data;
  logic [SIZE_W-1:0] access_size;
  logic              format_error;
  logic              glyph_done;

  modport source (output valid, output write_enable, output byte_offset,
                  output write_data, output access_size, output format_error,
                  output glyph_done, input ready);
  modport sink   (input valid, input write_enable, input byte_offset,
                  input write_data, input access_size, input format_error,
                  input glyph_done, output ready);
endinterface

@@ rtl/core/gbcp_cfg_if.sv @@
// Configuration write channel.
interface gbcp_cfg_if;
  import gbcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] idx;
  logic [CDAT_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ rtl/core/glyph_blit_clip_pixel_pack.sv @@
// Glyph blitter top level: placement, clipping, offset and pixel packing.
//
// Takes glyph pixels in raster order, one item per clock unless the output
// stalls, and returns one result item per pixel via the stage one and two
// registers. Stage one latches the pixel together with its screen position,
// formed from the origin registers and the column/row counters; stage two
// clips against the screen, forms row * line_bytes + column * pixel_bytes
// with one 13x15 multiplier and packs the color (8bpp low byte, RGB565 or
// 32bpp). Throughput is one item per cycle; both stages advance together
// and the input is held off only while both stage registers are full and
// the output item is not taken. A clipped pixel or an unsupported format
// gives write_enable 0 with zero offset, data and size; format_error is set
// only for an on-screen pixel in the unsupported format. glyph_done marks
// the last pixel of the glyph, after which the counters restart.
// Configuration writes are taken at any time (cfg ready is always high) but
// are only meant while idle; they never reset the counters.
`include "glyph_blit_clip_pixel_pack_defines.svh"

module glyph_blit_clip_pixel_pack (
  input logic         clk,
  input logic         rst_n,
  gbcp_pix_if.sink    in_ch,
  gbcp_wr_if.source   out_ch,
  gbcp_cfg_if.sink    cfg_ch
);
  import gbcp_pkg::*;

  // Configuration registers
  logic [ORG_W-1:0]   origin_x_r, origin_y_r;
  logic [GSIDE_W-1:0] glyph_width_r, glyph_rows_r;
  logic [SSIDE_W-1:0] screen_width_r, screen_height_r;
  logic [LB_W-1:0]    line_bytes_r;
  logic [FMT_W-1:0]   pixel_format_r;

  // Glyph counters
  logic [CNT_W-1:0] col_r, col_nxt, row_r, row_nxt;

  // Stage one
  logic             s1_vld_r, s1_vld_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [POS_W-1:0] s1_px_r, s1_py_r;
  logic             s1_last_r;

  // Stage two / output
  logic              out_vld_r, out_vld_nxt;
  logic              out_we_r, out_we_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;
  logic              out_err_r, out_err_nxt;
  logic              out_done_r;

  logic in_acc, s1_adv, out_free;
  logic cfg_wr;

  logic [CMP_W-1:0] w_eff, h_eff;
  logic             row_end, last_now;
  logic [POS_W-1:0] px_now, py_now;

  logic               visible;
  logic [SSIDE_W-1:0] sw_eff, sh_eff;
  logic [PROD_W-1:0]  row_prod;
  logic [OFF_W-1:0]   col_term;

  // ---------------------------------------------------------------- handshake
  assign out_free     = !out_vld_r || out_ch.ready;
  assign s1_adv       = s1_vld_r && out_free;
  assign in_ch.ready  = !s1_vld_r || out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      glyph_width_r   <= GSIDE_W'(1);
      glyph_rows_r    <= GSIDE_W'(1);
      screen_width_r  <= SSIDE_W'(480);
      screen_height_r <= SSIDE_W'(272);
      line_bytes_r    <= LB_W'(960);
      pixel_format_r  <= FMT_RGB565;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_ch.idx))
        REG_ORIGIN_X:      origin_x_r      <= cfg_ch.data[ORG_W-1:0];
        REG_ORIGIN_Y:      origin_y_r      <= cfg_ch.data[ORG_W-1:0];
        REG_GLYPH_WIDTH:   glyph_width_r   <= cfg_ch.data[GSIDE_W-1:0];
        REG_GLYPH_ROWS:    glyph_rows_r    <= cfg_ch.data[GSIDE_W-1:0];
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_ch.data[SSIDE_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_ch.data[SSIDE_W-1:0];
        REG_LINE_BYTES:    line_bytes_r    <= cfg_ch.data[LB_W-1:0];
        REG_PIXEL_FORMAT:  pixel_format_r  <= cfg_ch.data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- counters
  // A counter at or past the last index ends its row or glyph.
  always_comb begin
    w_eff    = CMP_W'(glyph_side(glyph_width_r));
    h_eff    = CMP_W'(glyph_side(glyph_rows_r));
    row_end  = (CMP_W'(col_r) + CMP_W'(1)) >= w_eff;
    last_now = row_end && ((CMP_W'(row_r) + CMP_W'(1)) >= h_eff);
    px_now   = POS_W'($signed(origin_x_r)) + POS_W'(col_r);
    py_now   = POS_W'($signed(origin_y_r)) + POS_W'(row_r);

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_now) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------- stage one
  assign s1_vld_nxt = in_acc || (s1_vld_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_ch.pixel_color;
      s1_px_r   <= px_now;
      s1_py_r   <= py_now;
      s1_last_r <= last_now;
    end
  end

  // ---------------------------------------------------------------- stage two
  // Clip, pack, and form the byte offset.
  always_comb begin
    sw_eff  = screen_side(screen_width_r);
    sh_eff  = screen_side(screen_height_r);
    visible = !s1_px_r[POS_W-1] && !s1_py_r[POS_W-1] &&
              (s1_px_r[POS_W-2:0] < sw_eff) && (s1_py_r[POS_W-2:0] < sh_eff);
    row_prod = PROD_W'(s1_py_r[POS_W-2:0]) * PROD_W'(line_bytes_r);

    out_we_nxt   = 1'b0;
    out_data_nxt = '0;
    out_size_nxt = SIZE_BYTE;
    out_err_nxt  = 1'b0;
    col_term     = '0;
    if (visible) begin
      unique case (pix_fmt_t'(pixel_format_r))
        FMT_8BPP: begin
          out_we_nxt   = 1'b1;
          out_data_nxt = DATA_W'(s1_pix_r[7:0]);
          out_size_nxt = SIZE_BYTE;
          col_term     = OFF_W'(s1_px_r[POS_W-2:0]);
        end
        FMT_RGB565: begin
          out_we_nxt   = 1'b1;
          out_data_nxt = DATA_W'(pack_rgb565(s1_pix_r));
          out_size_nxt = SIZE_HALF;
          col_term     = OFF_W'({s1_px_r[POS_W-2:0], 1'b0});
        end
        FMT_32BPP: begin
          out_we_nxt   = 1'b1;
          out_data_nxt = DATA_W'(s1_pix_r);
          out_size_nxt = SIZE_WORD;
          col_term     = OFF_W'({s1_px_r[POS_W-2:0], 2'b00});
        end
        default: out_err_nxt = 1'b1;
      endcase
    end
    out_off_nxt = out_we_nxt ? (row_prod[OFF_W-1:0] + col_term) : '0;
    out_vld_nxt = s1_adv || (out_vld_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_we_r   <= out_we_nxt;
      out_off_r  <= out_off_nxt;
      out_data_r <= out_data_nxt;
      out_size_r <= out_size_nxt;
      out_err_r  <= out_err_nxt;
      out_done_r <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.write_enable = out_we_r;
  assign out_ch.byte_offset  = out_off_r;
  assign out_ch.write_data   = out_data_r;
  assign out_ch.access_size  = out_size_r;
  assign out_ch.format_error = out_err_r;
  assign out_ch.glyph_done   = out_done_r;

  // ---------------------------------------------------------------- checks
  `GBCP_ASSERT_NEXT(a_last_restarts, in_acc && last_now, col_r == '0 && row_r == '0)
  `GBCP_ASSERT_NOW(a_nowrite_zero, out_vld_r && !out_we_r,
                   out_off_r == '0 && out_data_r == '0 && out_size_r == SIZE_BYTE)
  `GBCP_ASSERT_NOW(a_we_err_excl, out_vld_r && out_we_r,
                   !out_err_r && pixel_format_r != FMT_BAD)
  `GBCP_ASSERT_NOW(a_stage_flow, s1_vld_r && !out_free, !in_ch.ready)

endmodule
